// ===== hdl/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types, constants and the CRC-16/Modbus byte update for the command
// frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

    // frame layout
    localparam int FRAME_LEN = 9;
    localparam int CRC_LEN   = 7;
    localparam int REPLY_LEN = 6;

    // protocol constants
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  FUNC_CODE    = 8'h02;
    localparam logic [7:0]  DEV_FAN      = 8'h01;
    localparam logic [7:0]  DEV_EXHAUST  = 8'h02;
    localparam logic [7:0]  DEV_MANUAL   = 8'h03;
    localparam logic [7:0]  STAT_OK      = 8'h01;
    localparam logic [7:0]  STAT_CRC_ERR = 8'h02;
    localparam logic [7:0]  CODE_BAD_DEV = 8'hFF;
    localparam logic [7:0]  CODE_BAD_ADR = 8'hFE;
    localparam logic [7:0]  DUTY_MAX     = 8'd100;

    // reset values of the settings
    localparam logic [6:0]  DUTY_RESET    = 7'd13;
    localparam logic [15:0] ON_RESET      = 16'd500;
    localparam logic [15:0] INTERVAL_RESET = 16'd12000;

    // configuration register indexes
    localparam logic [0:0] REG_RX_ADDRESS = 1'b0;
    localparam logic [0:0] REG_TX_ADDRESS = 1'b1;

    // classification of a finished frame
    typedef enum logic [2:0] {
        K_BAD_ADDR,
        K_UNKNOWN,
        K_FAN,
        K_EXHAUST,
        K_MANUAL
    } kind_t;

    // request passed from the front to the back
    typedef struct packed {
        kind_t       kind;
        logic [15:0] crc;       // crc over the bytes actually received (up to 7)
        logic [2:0]  pad;       // zero bytes still to fold into crc
        logic [15:0] got;       // received crc, high byte first
        logic [7:0]  duty;
        logic [15:0] on_time;
        logic [15:0] interval;
    } cmd_t;

    // one reply byte with the settings that go along with it
    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        last;
        logic [6:0]  fan_duty;
        logic [15:0] exhaust_on_time;
        logic [15:0] exhaust_interval;
        logic        manual_trigger;
    } reply_t;

    // crc-16/modbus update by one byte, lsb first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/crc16_command_frame_parser.sv =====
// ----------------------------------------------------------------------------
// crc16_command_frame_parser
// Command frame parser with crc-16/modbus check and six-byte reply.
// ----------------------------------------------------------------------------
// Input: one byte per cycle, sustained; full rises only while the request queue is full.
// Path: with the back idle, a finished request passes the request queue to the back,
// which folds a zero byte into the crc per byte missing below seven (zero fill).
// Reply: six bytes, one per cycle while the reply queue has room, then the next request.
// Reset: rst_n empties queues, zeroes counters, loads reset settings; no clearing pass.
module crc16_command_frame_parser import cfp_pkg::*; #(
    parameter int CMD_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  tx_byte,
    output logic        last,
    output logic [6:0]  fan_duty,
    output logic [15:0] exhaust_on_time,
    output logic [15:0] exhaust_interval,
    output logic        manual_trigger,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic   [7:0] rx_address_reg;
    logic   [7:0] tx_address_reg;
    logic         accept;
    logic         cmd_push;
    cmd_t         cmd_in;
    logic         cmd_full;
    logic         cmd_empty;
    logic         cmd_pop;
    cmd_t         cmd_out;
    logic         out_push;
    logic         out_full;
    reply_t       out_in;
    reply_t       out_head;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_address_reg <= 8'h0C;
            tx_address_reg <= 8'h0E;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RX_ADDRESS: rx_address_reg <= cfg_data;
                REG_TX_ADDRESS: tx_address_reg <= cfg_data;
                default:        rx_address_reg <= rx_address_reg;
            endcase
        end
    end

    // front: byte collection and classification
    cfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .frame_end  (frame_end),
        .rx_address (rx_address_reg),
        .cmd_push   (cmd_push),
        .cmd_data   (cmd_in)
    );

    // request queue between front and back
    cfp_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_out),
        .empty (cmd_empty)
    );

    // back: settings update and reply generation
    cfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd_data   (cmd_out),
        .cmd_pop    (cmd_pop),
        .tx_address (tx_address_reg),
        .out_full   (out_full),
        .out_push   (out_push),
        .out_data   (out_in)
    );

    // reply queue
    cfp_fifo #(
        .WIDTH ($bits(reply_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (out_in),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_head),
        .empty (empty)
    );

    assign tx_byte          = out_head.tx_byte;
    assign last             = out_head.last;
    assign fan_duty         = out_head.fan_duty;
    assign exhaust_on_time  = out_head.exhaust_on_time;
    assign exhaust_interval = out_head.exhaust_interval;
    assign manual_trigger   = out_head.manual_trigger;

endmodule

// ===== hdl/cfp_fifo.sv =====
// ----------------------------------------------------------------------------
// cfp_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module cfp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push_ok;
    logic             pop_ok;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push_ok && !pop_ok)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_ok && !push_ok)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== hdl/cfp_front.sv =====
// ----------------------------------------------------------------------------
// cfp_front
// Collects frame bytes, runs the crc over bytes 0 to 6 as they arrive and
// classifies the frame into a request at its last byte.
// ----------------------------------------------------------------------------
module cfp_front import cfp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic       frame_end,
    input  logic [7:0] rx_address,
    output logic       cmd_push,
    output cmd_t       cmd_data
);

    logic [3:0]  byte_count_reg;
    logic [15:0] crc_reg;
    logic [7:0]  frame_reg [FRAME_LEN];
    logic [7:0]  cur [FRAME_LEN];
    logic [15:0] crc_step;
    logic        in_crc;
    logic        addr_ok;

    assign in_crc   = (byte_count_reg < 4'(CRC_LEN));
    assign crc_step = crc16_update(crc_reg, rx_byte);
    assign cmd_push = accept && frame_end;

    // frame view with the current byte merged in, missing bytes as zero
    always_comb
    begin
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            if (4'(i) < byte_count_reg)
            begin
                cur[i] = frame_reg[i];
            end
            else if (4'(i) == byte_count_reg)
            begin
                cur[i] = rx_byte;
            end
            else
            begin
                cur[i] = 8'h00;
            end
        end
    end

    // classify the frame
    always_comb
    begin
        addr_ok           = (cur[0] == rx_address) && (cur[1] == FUNC_CODE);
        cmd_data.crc      = in_crc ? crc_step : crc_reg;
        cmd_data.pad      = in_crc ? 3'(4'(CRC_LEN - 1) - byte_count_reg) : 3'd0;
        cmd_data.got      = {cur[7], cur[8]};
        cmd_data.duty     = cur[6];
        cmd_data.on_time  = {cur[3], cur[4]};
        cmd_data.interval = {cur[5], cur[6]};
        if (!addr_ok)
        begin
            cmd_data.kind = K_BAD_ADDR;
        end
        else if (cur[2] == DEV_FAN)
        begin
            cmd_data.kind = K_FAN;
        end
        else if (cur[2] == DEV_EXHAUST)
        begin
            cmd_data.kind = K_EXHAUST;
        end
        else if (cur[2] == DEV_MANUAL)
        begin
            cmd_data.kind = K_MANUAL;
        end
        else
        begin
            cmd_data.kind = K_UNKNOWN;
        end
    end

    // byte count and running crc
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            crc_reg        <= CRC_INIT;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                byte_count_reg <= '0;
                crc_reg        <= CRC_INIT;
            end
            else
            begin
                if (byte_count_reg < 4'(FRAME_LEN))
                begin
                    byte_count_reg <= byte_count_reg + 1'b1;
                end
                if (in_crc)
                begin
                    crc_reg <= crc_step;
                end
            end
        end
    end

    // frame bytes
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            if (accept && (4'(i) == byte_count_reg))
            begin
                frame_reg[i] <= rx_byte;
            end
        end
    end

endmodule

// ===== hdl/cfp_back.sv =====
// ----------------------------------------------------------------------------
// cfp_back
// Finishes the frame crc, applies the request to the settings, emits six reply
// bytes one per cycle while the reply queue has room and builds the reply crc.
// ----------------------------------------------------------------------------
module cfp_back import cfp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_empty,
    input  cmd_t       cmd_data,
    output logic       cmd_pop,
    input  logic [7:0] tx_address,
    input  logic       out_full,
    output logic       out_push,
    output reply_t     out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_REPLY
    } state_t;

    state_t      state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [2:0]  pad_reg, pad_next;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rcrc_reg, rcrc_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  status_reg, status_next;
    logic [6:0]  duty_reg, duty_next;
    logic [15:0] on_reg, on_next;
    logic [15:0] int_reg, int_next;
    logic        manual_reg, manual_next;
    logic        crc_ok;
    logic        load;
    logic [7:0]  byte_sel;

    assign crc_ok = (crc_reg == cmd_reg.got);

    // sequencer and reply build
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        pad_next    = pad_reg;
        idx_next    = idx_reg;
        crc_next    = crc_reg;
        rcrc_next   = rcrc_reg;
        id_next     = id_reg;
        status_next = status_reg;
        duty_next   = duty_reg;
        on_next     = on_reg;
        int_next    = int_reg;
        manual_next = manual_reg;
        load        = 1'b0;
        out_push    = 1'b0;
        byte_sel    = 8'h00;

        case (state_reg)
            S_IDLE:
            begin
                load = !cmd_empty;
            end
            S_PAD:
            begin
                crc_next = crc16_update(crc_reg, 8'h00);
                pad_next = pad_reg - 1'b1;
                if (pad_reg == 3'd1)
                begin
                    state_next = S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    case (idx_reg)
                        3'd0:
                        begin
                            byte_sel    = tx_address;
                            manual_next = 1'b0;
                            case (cmd_reg.kind)
                                K_BAD_ADDR:
                                begin
                                    id_next     = CODE_BAD_ADR;
                                    status_next = CODE_BAD_ADR;
                                end
                                K_FAN:
                                begin
                                    id_next     = DEV_FAN;
                                    status_next = crc_ok ? STAT_OK : STAT_CRC_ERR;
                                    if (crc_ok)
                                    begin
                                        duty_next = (cmd_reg.duty >= DUTY_MAX) ?
                                                    DUTY_MAX[6:0] : cmd_reg.duty[6:0];
                                    end
                                end
                                K_EXHAUST:
                                begin
                                    id_next     = DEV_EXHAUST;
                                    status_next = crc_ok ? STAT_OK : STAT_CRC_ERR;
                                    if (crc_ok)
                                    begin
                                        on_next  = cmd_reg.on_time;
                                        int_next = cmd_reg.interval;
                                    end
                                end
                                K_MANUAL:
                                begin
                                    id_next     = DEV_MANUAL;
                                    status_next = crc_ok ? STAT_OK : STAT_CRC_ERR;
                                    manual_next = crc_ok;
                                end
                                default:
                                begin
                                    id_next     = CODE_BAD_DEV;
                                    status_next = CODE_BAD_DEV;
                                end
                            endcase
                            rcrc_next = crc16_update(CRC_INIT, byte_sel);
                        end
                        3'd1:
                        begin
                            byte_sel  = FUNC_CODE;
                            rcrc_next = crc16_update(rcrc_reg, byte_sel);
                        end
                        3'd2:
                        begin
                            byte_sel  = id_reg;
                            rcrc_next = crc16_update(rcrc_reg, byte_sel);
                        end
                        3'd3:
                        begin
                            byte_sel  = status_reg;
                            rcrc_next = crc16_update(rcrc_reg, byte_sel);
                        end
                        3'd4:
                        begin
                            byte_sel = rcrc_reg[15:8];
                        end
                        default:
                        begin
                            byte_sel = rcrc_reg[7:0];
                            if (cmd_empty)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // take the next request
        if (load)
        begin
            cmd_next   = cmd_data;
            crc_next   = cmd_data.crc;
            pad_next   = cmd_data.pad;
            idx_next   = 3'd0;
            state_next = (cmd_data.pad == 3'd0) ? S_REPLY : S_PAD;
        end
    end

    assign cmd_pop = load;

    // reply entry carries the settings as they stand after this frame
    always_comb
    begin
        out_data.tx_byte          = byte_sel;
        out_data.last             = (idx_reg == 3'(REPLY_LEN - 1));
        out_data.fan_duty         = duty_next;
        out_data.exhaust_on_time  = on_next;
        out_data.exhaust_interval = int_next;
        out_data.manual_trigger   = manual_next;
    end

    // state and settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pad_reg    <= '0;
            idx_reg    <= '0;
            duty_reg   <= DUTY_RESET;
            on_reg     <= ON_RESET;
            int_reg    <= INTERVAL_RESET;
            manual_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pad_reg    <= pad_next;
            idx_reg    <= idx_next;
            duty_reg   <= duty_next;
            on_reg     <= on_next;
            int_reg    <= int_next;
            manual_reg <= manual_next;
        end
    end

    // request payload and crc work registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        crc_reg    <= crc_next;
        rcrc_reg   <= rcrc_next;
        id_reg     <= id_next;
        status_reg <= status_next;
    end

endmodule

// ===== hdl/cfp_check.sv =====
// ----------------------------------------------------------------------------
// cfp_check
// Port-level checks for the command frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module cfp_check (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic [7:0]  rx_byte,
    input logic        frame_end,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  tx_byte,
    input logic        last,
    input logic [6:0]  fan_duty,
    input logic [15:0] exhaust_on_time,
    input logic [15:0] exhaust_interval,
    input logic        manual_trigger,
    input logic        cfg_write,
    input logic [0:0]  cfg_index,
    input logic [7:0]  cfg_data
);

    // a waiting reply byte stays until taken
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("reply byte withdrawn before pop");

    // a stalled reply byte keeps its value
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(tx_byte) && $stable(last)))
        else $error("reply byte changed while stalled");

    // fan duty is clamped
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (fan_duty <= 7'd100))
        else $error("fan duty above 100");

    // settings do not change inside one reply
    a_reply_settings: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last) |=>
        (empty || ($stable(fan_duty) && $stable(exhaust_on_time) &&
                   $stable(exhaust_interval) && $stable(manual_trigger))))
        else $error("settings changed within a reply");

endmodule

bind crc16_command_frame_parser cfp_check u_cfp_check (.*);
